// ===== src/eida_pkg.sv =====
// Package for the entity id allocator: sizes, codes and shared types.
// No dependencies; the design files refer to it by scoped names, the testbench imports it.
package eida_pkg;

  localparam int MAX_ENTITIES = 1024;
  localparam int SYSTEM_SLOTS = 4;
  localparam int MASK_REGS    = 4;
  localparam int SLOTS_USED   = (SYSTEM_SLOTS < MASK_REGS) ? SYSTEM_SLOTS : MASK_REGS;

  localparam int OP_W      = 2;
  localparam int ID_W      = 10;
  localparam int MASK_W    = 64;
  localparam int STATUS_W  = 2;
  localparam int MEMBER_W  = 4;
  localparam int SC_W      = 3;
  localparam int CFG_IDX_W = 3;

  localparam int IDX_W   = $clog2(MAX_ENTITIES);
  localparam int CNT_W   = IDX_W + 1;
  localparam int ENTRY_W = MASK_W + 1;  // in-use flag on top of the mask

  localparam int IN_RAW_W     = OP_W + ID_W + MASK_W;
  localparam int IN_TDATA_W   = ((IN_RAW_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W  = STATUS_W + ID_W + MEMBER_W + MASK_W;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [MASK_W-1:0] mask_t;
  typedef mask_t [MASK_REGS-1:0] sys_masks_t;

  typedef enum logic [OP_W-1:0] {
    OP_CREATE  = 2'd0,
    OP_DESTROY = 2'd1,
    OP_ADD     = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_NO_FREE  = 2'd1,
    STAT_NO_SYS   = 2'd2,
    STAT_NOT_USED = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    FSM_CLEAR,
    FSM_IDLE,
    FSM_EXEC
  } fsm_e;

  localparam logic [CFG_IDX_W-1:0] CFG_SYSTEM_COUNT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYSTEM_MASK_0 = 3'd1;

  // Commands from the controller to the free list.
  typedef struct packed {
    logic clr_we;
    idx_t clr_idx;
    logic pop;
    logic push;
    idx_t push_id;
  } fl_cmd_t;

  // Free list status seen by the controller.
  typedef struct packed {
    idx_t head_id;
    logic empty;
    logic full;
  } fl_stat_t;

endpackage

// ===== src/eida_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module eida_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/eida_free_list.sv =====
// FIFO free list of entity ids: queue RAM plus head, tail and fill count.
// Depends on eida_pkg and eida_ram.
module eida_free_list (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  eida_pkg::fl_cmd_t  cmd_i,
  output eida_pkg::fl_stat_t stat_o
);

  eida_pkg::idx_t head_q, head_d;
  eida_pkg::idx_t tail_q, tail_d;
  logic [eida_pkg::CNT_W-1:0] count_q, count_d;

  logic           ram_we;
  eida_pkg::idx_t ram_waddr;
  eida_pkg::idx_t ram_wdata;
  eida_pkg::idx_t ram_rdata;

  function automatic eida_pkg::idx_t ring_next(eida_pkg::idx_t p);
    ring_next = (p == eida_pkg::IDX_W'(eida_pkg::MAX_ENTITIES - 1)) ? '0 : p + 1'b1;
  endfunction

  // Clearing pass loads entry i with id i; otherwise pushes land at the tail.
  always_comb begin
    ram_we    = cmd_i.clr_we | cmd_i.push;
    ram_waddr = cmd_i.clr_we ? cmd_i.clr_idx : tail_q;
    ram_wdata = cmd_i.clr_we ? cmd_i.clr_idx : cmd_i.push_id;
  end

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (cmd_i.pop) begin
      head_d  = ring_next(head_q);
      count_d = count_q - 1'b1;
    end else if (cmd_i.push) begin
      tail_d  = ring_next(tail_q);
      count_d = count_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= eida_pkg::CNT_W'(eida_pkg::MAX_ENTITIES);
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  // Head entry is read every cycle; it is stable while a request executes.
  eida_ram #(
    .WIDTH(eida_pkg::IDX_W),
    .DEPTH(eida_pkg::MAX_ENTITIES)
  ) u_queue_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (1'b1),
    .raddr_i(head_q),
    .rdata_o(ram_rdata)
  );

  assign stat_o.head_id = ram_rdata;
  assign stat_o.empty   = (count_q == '0);
  assign stat_o.full    = (count_q == eida_pkg::CNT_W'(eida_pkg::MAX_ENTITIES));

endmodule

// ===== src/eida_ctrl.sv =====
// Request sequencer: clearing pass, read-modify-write of the mask store,
// free list commands, system match and the result register.
// Depends on eida_pkg.
module eida_ctrl (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                req_valid_i,
  output logic                                req_ready_o,
  input  logic [eida_pkg::IN_TDATA_W-1:0]     req_data_i,
  output logic                                rsp_valid_o,
  input  logic                                rsp_ready_i,
  output logic [eida_pkg::OUT_TDATA_W-1:0]    rsp_data_o,
  input  logic [eida_pkg::SC_W-1:0]           sys_count_i,
  input  eida_pkg::sys_masks_t                sys_masks_i,
  output logic                                mem_we_o,
  output eida_pkg::idx_t                      mem_waddr_o,
  output logic [eida_pkg::ENTRY_W-1:0]        mem_wdata_o,
  output logic                                mem_re_o,
  output eida_pkg::idx_t                      mem_raddr_o,
  input  logic [eida_pkg::ENTRY_W-1:0]        mem_rdata_i,
  output eida_pkg::fl_cmd_t                   fl_cmd_o,
  input  eida_pkg::fl_stat_t                  fl_stat_i
);

  eida_pkg::fsm_e state_q, state_d;
  eida_pkg::idx_t clr_q, clr_d;

  eida_pkg::op_e              op_q;
  logic [eida_pkg::ID_W-1:0]  id_q;
  eida_pkg::mask_t            add_q;

  logic                                 out_valid_q, out_valid_d;
  logic [eida_pkg::OUT_TDATA_W-1:0]     out_data_q,  out_data_d;

  logic accept;
  logic clr_last;

  eida_pkg::status_e            status;
  logic [eida_pkg::ID_W-1:0]    rid;
  logic [eida_pkg::MEMBER_W-1:0] member;
  eida_pkg::mask_t              emask;
  eida_pkg::mask_t              new_mask;
  logic [eida_pkg::SC_W-1:0]    slots;
  logic                         in_range;
  logic                         entry_used;

  assign clr_last = (clr_q == eida_pkg::IDX_W'(eida_pkg::MAX_ENTITIES - 1));
  assign accept   = req_valid_i && req_ready_o;

  // Next state
  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    case (state_q)
      eida_pkg::FSM_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_last) begin
          state_d = eida_pkg::FSM_IDLE;
        end
      end
      eida_pkg::FSM_IDLE: begin
        if (accept) begin
          state_d = eida_pkg::FSM_EXEC;
        end
      end
      eida_pkg::FSM_EXEC: begin
        state_d = eida_pkg::FSM_IDLE;
      end
      default: begin
        state_d = eida_pkg::FSM_CLEAR;
      end
    endcase
  end

  // Match logic on the merged mask
  assign entry_used = mem_rdata_i[eida_pkg::MASK_W];
  assign new_mask   = mem_rdata_i[eida_pkg::MASK_W-1:0] | add_q;
  assign in_range   = ({1'b0, id_q} < (eida_pkg::ID_W + 1)'(eida_pkg::MAX_ENTITIES));
  assign slots      = (sys_count_i > eida_pkg::SC_W'(eida_pkg::SLOTS_USED)) ?
                      eida_pkg::SC_W'(eida_pkg::SLOTS_USED) : sys_count_i;

  // Outputs
  always_comb begin
    req_ready_o = 1'b0;
    mem_we_o    = 1'b0;
    mem_waddr_o = id_q[eida_pkg::IDX_W-1:0];
    mem_wdata_o = '0;
    mem_re_o    = 1'b0;
    mem_raddr_o = req_data_i[eida_pkg::OP_W +: eida_pkg::IDX_W];
    fl_cmd_o    = '0;
    fl_cmd_o.clr_idx = clr_q;
    fl_cmd_o.push_id = id_q[eida_pkg::IDX_W-1:0];
    status      = eida_pkg::STAT_OK;
    rid         = id_q;
    member      = '0;
    emask       = '0;
    out_valid_d = out_valid_q && !rsp_ready_i;
    out_data_d  = out_data_q;

    case (state_q)
      eida_pkg::FSM_CLEAR: begin
        mem_we_o        = 1'b1;
        mem_waddr_o     = clr_q;
        fl_cmd_o.clr_we = 1'b1;
      end
      eida_pkg::FSM_IDLE: begin
        req_ready_o = !out_valid_q || rsp_ready_i;
        mem_re_o    = accept;
      end
      eida_pkg::FSM_EXEC: begin
        case (op_q)
          eida_pkg::OP_CREATE: begin
            if (fl_stat_i.empty) begin
              status = eida_pkg::STAT_NO_FREE;
              rid    = '0;
            end else begin
              rid          = eida_pkg::ID_W'(fl_stat_i.head_id);
              fl_cmd_o.pop = 1'b1;
              mem_we_o     = 1'b1;
              mem_waddr_o  = fl_stat_i.head_id;
              mem_wdata_o  = {1'b1, {eida_pkg::MASK_W{1'b0}}};
            end
          end
          eida_pkg::OP_DESTROY: begin
            if (!in_range) begin
              status = eida_pkg::STAT_NOT_USED;
            end else if (!entry_used) begin
              status = eida_pkg::STAT_NOT_USED;
              emask  = mem_rdata_i[eida_pkg::MASK_W-1:0];
            end else begin
              mem_we_o      = 1'b1;
              fl_cmd_o.push = !fl_stat_i.full;
            end
          end
          eida_pkg::OP_ADD: begin
            if (!in_range) begin
              status = eida_pkg::STAT_NOT_USED;
            end else begin
              mem_we_o    = 1'b1;
              mem_wdata_o = {entry_used, new_mask};
              emask       = new_mask;
              if (slots == '0) begin
                status = eida_pkg::STAT_NO_SYS;
              end else begin
                for (int k = 0; k < eida_pkg::MEMBER_W; k++) begin
                  if (k < eida_pkg::SLOTS_USED) begin
                    member[k] = (eida_pkg::SC_W'(k) < slots) &&
                                ((new_mask & sys_masks_i[k]) == sys_masks_i[k]);
                  end
                end
              end
            end
          end
          default: begin
            // unused opcode: echo the id, touch nothing
          end
        endcase
        out_valid_d = 1'b1;
        out_data_d  = {emask, member, rid, status};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= eida_pkg::FSM_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    if (accept) begin
      op_q  <= eida_pkg::op_e'(req_data_i[eida_pkg::OP_W-1:0]);
      id_q  <= req_data_i[eida_pkg::OP_W +: eida_pkg::ID_W];
      add_q <= req_data_i[eida_pkg::OP_W + eida_pkg::ID_W +: eida_pkg::MASK_W];
    end
  end

  assign rsp_valid_o = out_valid_q;
  assign rsp_data_o  = out_data_q;

endmodule

// ===== src/entity_id_allocator_with_mask_match.sv =====
// Entity id allocator with system mask match: top level.
// Depends on eida_pkg, eida_ram, eida_free_list and eida_ctrl.
//
// Usage
//   s_axis carries one request: create, destroy or add-mask on an entity id.
//   m_axis returns exactly one result per request, in order.
//   cfg_* writes system_count (index 0) and system masks 0..3 (index 1..4);
//   other indexes are dropped. cfg_ready_o is always high; write only while
//   no request is outstanding.
// Timing
//   A request is accepted in the idle state, where the mask store and the
//   free list head are read, and then passes through the execute state, which
//   writes back and loads the result register. The result shows on m_axis the cycle
//   after that. One request is in flight at a time; no new request is taken
//   until the last has been executed, set by the read-then-write of the mask RAM.
// Reset
//   After reset a clearing pass over all 1024 entries loads the free list with ids
//   in ascending order and zeroes every mask and in-use flag; s_axis_tready
//   stays low until it ends. Configuration writes are taken during the pass.
// Backpressure
//   While a result waits with m_axis_tready low, no new request is taken.
module entity_id_allocator_with_mask_match (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // op[1:0], entity_id[11:2], added_mask[75:12], zero[79:76]
  input  logic [eida_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // status[1:0], result_id[11:2], member_of[15:12], entity_mask[79:16]
  output logic [eida_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [eida_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [eida_pkg::MASK_W-1:0]         cfg_data_i
);

  logic [eida_pkg::SC_W-1:0] sys_count_q;
  eida_pkg::sys_masks_t      sys_masks_q;

  logic                               mem_we;
  eida_pkg::idx_t                     mem_waddr;
  logic [eida_pkg::ENTRY_W-1:0]       mem_wdata;
  logic                               mem_re;
  eida_pkg::idx_t                     mem_raddr;
  logic [eida_pkg::ENTRY_W-1:0]       mem_rdata;

  eida_pkg::fl_cmd_t  fl_cmd;
  eida_pkg::fl_stat_t fl_stat;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sys_count_q <= '0;
      sys_masks_q <= '0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == eida_pkg::CFG_SYSTEM_COUNT) begin
        sys_count_q <= cfg_data_i[eida_pkg::SC_W-1:0];
      end
      for (int k = 0; k < eida_pkg::MASK_REGS; k++) begin
        if (cfg_index_i == eida_pkg::CFG_IDX_W'(int'(eida_pkg::CFG_SYSTEM_MASK_0) + k)) begin
          sys_masks_q[k] <= cfg_data_i;
        end
      end
    end
  end

  eida_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(s_axis_tvalid),
    .req_ready_o(s_axis_tready),
    .req_data_i (s_axis_tdata),
    .rsp_valid_o(m_axis_tvalid),
    .rsp_ready_i(m_axis_tready),
    .rsp_data_o (m_axis_tdata),
    .sys_count_i(sys_count_q),
    .sys_masks_i(sys_masks_q),
    .mem_we_o   (mem_we),
    .mem_waddr_o(mem_waddr),
    .mem_wdata_o(mem_wdata),
    .mem_re_o   (mem_re),
    .mem_raddr_o(mem_raddr),
    .mem_rdata_i(mem_rdata),
    .fl_cmd_o   (fl_cmd),
    .fl_stat_i  (fl_stat)
  );

  // Mask store: {in_use, mask} per entity
  eida_ram #(
    .WIDTH(eida_pkg::ENTRY_W),
    .DEPTH(eida_pkg::MAX_ENTITIES)
  ) u_mask_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  eida_free_list u_free_list (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (fl_cmd),
    .stat_o(fl_stat)
  );

endmodule

// ===== src/eida_checker.sv =====
// Port-level checks for the entity id allocator, bound to the top level.
// Depends on eida_pkg and entity_id_allocator_with_mask_match.
module eida_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [eida_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  logic s_acc;
  assign s_acc = s_axis_tvalid && s_axis_tready;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

  // each request yields its result once it has passed the execute state
  a_rsp_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |-> ##2 m_axis_tvalid)
    else $error("result missing two cycles after request");

  // the result register is free when a request is accepted
  a_no_stale_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> !m_axis_tvalid)
    else $error("result pending behind a new request");

  // one request at a time
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> !s_axis_tready)
    else $error("request accepted during execute");

  // no new request while a result is stalled
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("request taken while result stalled");

endmodule

bind entity_id_allocator_with_mask_match eida_checker u_eida_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

// ===== verif/entity_id_allocator_with_mask_match_tb.sv =====
// Self-checking testbench for entity_id_allocator_with_mask_match.
// Needs eida_pkg and the RTL top. A table of directed requests runs first,
// then random traffic, checked against an in-bench allocator model or hand-written results.
module entity_id_allocator_with_mask_match_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import eida_pkg::*;

  typedef struct packed {
    status_e               status;
    idx_t                  rid;
    logic [MEMBER_W-1:0]   member;
    mask_t                 mask;
  } alloc_result_t;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e              kind;
    op_e                    op;
    idx_t                   id;
    mask_t                  data;     // added mask, or register value for ROW_CFG
    logic [CFG_IDX_W-1:0]   reg_idx;
    logic                   typed;    // want holds a hand-written result
    alloc_result_t          want;
  } dir_row_t;

  localparam logic [CFG_IDX_W-1:0] CFG_PAST_END =
    CFG_IDX_W'(int'(CFG_SYSTEM_MASK_0) + MASK_REGS);
  localparam logic [CFG_IDX_W-1:0] CFG_TOP_IDX  = {CFG_IDX_W{1'b1}};
  localparam logic [CFG_IDX_W-1:0] CFG_SYSTEM_MASK_1 = CFG_IDX_W'(int'(CFG_SYSTEM_MASK_0) + 1);
  localparam logic [CFG_IDX_W-1:0] CFG_SYSTEM_MASK_2 = CFG_IDX_W'(int'(CFG_SYSTEM_MASK_0) + 2);
  localparam logic [CFG_IDX_W-1:0] CFG_SYSTEM_MASK_3 = CFG_IDX_W'(int'(CFG_SYSTEM_MASK_0) + 3);
  localparam mask_t ONES = {MASK_W{1'b1}};

  localparam int DIR_ROWS = 24;
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    '{ROW_CFG, OP_NONE,    10'd0,   64'd0,                  CFG_SYSTEM_COUNT,      1'b0, '0},
    '{ROW_CFG, OP_NONE,    10'd0,   ONES,                   CFG_SYSTEM_MASK_0,     1'b0, '0},
    '{ROW_CFG, OP_NONE,    10'd0,   64'd0,                  CFG_SYSTEM_MASK_1,     1'b0, '0},
    '{ROW_CFG, OP_NONE,    10'd0,   64'h0000_0000_0000_000F, CFG_SYSTEM_MASK_2,    1'b0, '0},
    '{ROW_CFG, OP_NONE,    10'd0,   64'h8000_0000_0000_0001, CFG_SYSTEM_MASK_3,    1'b0, '0},
    '{ROW_CFG, OP_NONE,    10'd0,   ONES,                   CFG_PAST_END,          1'b0, '0},
    '{ROW_CFG, OP_NONE,    10'd0,   64'h5,                  CFG_TOP_IDX,           1'b0, '0},
    // fresh free list hands out 0 then 1, id field ignored
    '{ROW_REQ, OP_CREATE,  10'h3FF, ONES,  CFG_SYSTEM_COUNT, 1'b1,
      '{STAT_OK, 10'd0, 4'd0, 64'd0}},
    '{ROW_REQ, OP_CREATE,  10'h000, 64'd0, CFG_SYSTEM_COUNT, 1'b1,
      '{STAT_OK, 10'd1, 4'd0, 64'd0}},
    // no systems configured: mask still written
    '{ROW_REQ, OP_ADD,     10'h000, ONES,  CFG_SYSTEM_COUNT, 1'b1,
      '{STAT_NO_SYS, 10'd0, 4'd0, ONES}},
    '{ROW_REQ, OP_DESTROY, 10'h3FF, 64'd0, CFG_SYSTEM_COUNT, 1'b1,
      '{STAT_NOT_USED, 10'h3FF, 4'd0, 64'd0}},
    '{ROW_REQ, OP_DESTROY, 10'h000, 64'd0, CFG_SYSTEM_COUNT, 1'b1,
      '{STAT_OK, 10'd0, 4'd0, 64'd0}},
    // double destroy is flagged, not queued twice
    '{ROW_REQ, OP_DESTROY, 10'h000, 64'd0, CFG_SYSTEM_COUNT, 1'b1,
      '{STAT_NOT_USED, 10'd0, 4'd0, 64'd0}},
    '{ROW_REQ, OP_NONE,    10'h2AA, 64'hAAAA_AAAA_AAAA_AAAA, CFG_SYSTEM_COUNT, 1'b1,
      '{STAT_OK, 10'h2AA, 4'd0, 64'd0}},
    '{ROW_REQ, OP_NONE,    10'h155, 64'h5555_5555_5555_5555, CFG_SYSTEM_COUNT, 1'b1,
      '{STAT_OK, 10'h155, 4'd0, 64'd0}},
    '{ROW_CFG, OP_NONE,    10'd0,   64'd4, CFG_SYSTEM_COUNT, 1'b0, '0},
    '{ROW_REQ, OP_ADD,     10'h001, 64'd0,  CFG_SYSTEM_COUNT, 1'b0, '0},
    '{ROW_REQ, OP_ADD,     10'h001, 64'hF,  CFG_SYSTEM_COUNT, 1'b0, '0},
    // add-mask on a free id is allowed; destroy then reports its stored mask
    '{ROW_REQ, OP_ADD,     10'h3FF, 64'h8000_0000_0000_0001, CFG_SYSTEM_COUNT, 1'b0, '0},
    '{ROW_REQ, OP_DESTROY, 10'h3FF, 64'd0,  CFG_SYSTEM_COUNT, 1'b0, '0},
    '{ROW_CFG, OP_NONE,    10'd0,   64'd7,  CFG_SYSTEM_COUNT, 1'b0, '0},
    '{ROW_REQ, OP_ADD,     10'h001, ONES,   CFG_SYSTEM_COUNT, 1'b0, '0},
    '{ROW_REQ, OP_CREATE,  10'h155, ONES,   CFG_SYSTEM_COUNT, 1'b0, '0},
    '{ROW_REQ, OP_DESTROY, 10'h001, 64'd0,  CFG_SYSTEM_COUNT, 1'b0, '0}
  };

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic [IN_TDATA_W-1:0]    s_axis_tdata = '0;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  logic [OUT_TDATA_W-1:0]   m_axis_tdata;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  logic                     cfg_valid_i = 1'b0;
  logic                     cfg_ready_o;
  logic [CFG_IDX_W-1:0]     cfg_index_i = '0;
  logic [MASK_W-1:0]        cfg_data_i = '0;

  entity_id_allocator_with_mask_match uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // allocator model state
  idx_t                 free_ids [$];
  idx_t                 live_ids [$];
  mask_t                ent_mask [MAX_ENTITIES] = '{default: '0};
  bit                   ent_live [MAX_ENTITIES] = '{default: 1'b0};
  logic [SC_W-1:0]      sys_count = '0;
  mask_t                sys_mask [MASK_REGS] = '{default: '0};
  alloc_result_t        result_q [$];

  int  err_cnt = 0;
  int  results_seen = 0;
  int  sink_hold = 0;
  bit  src_gaps = 1'b1;
  bit  snk_gaps = 1'b1;

  function automatic void model_reg_write(logic [CFG_IDX_W-1:0] idx, mask_t val);
    if (idx == CFG_SYSTEM_COUNT)
      sys_count = val[SC_W-1:0];
    else if (idx >= CFG_SYSTEM_MASK_0 && idx < CFG_PAST_END)
      sys_mask[$clog2(MASK_REGS)'(idx - CFG_SYSTEM_MASK_0)] = val;
  endfunction

  function automatic void model_alloc_op(op_e op, idx_t id, mask_t add);
    alloc_result_t r;
    int            n;
    int            hits [$];
    r = '0;
    n = (sys_count < SLOTS_USED) ? int'(sys_count) : SLOTS_USED;
    case (op)
      OP_CREATE: begin
        if (free_ids.size() == 0) begin
          r.status = STAT_NO_FREE;
        end else begin
          r.rid = free_ids.pop_front();
          ent_mask[r.rid] = '0;
          ent_live[r.rid] = 1'b1;
          live_ids.push_back(r.rid);
        end
      end
      OP_DESTROY: begin
        r.rid = id;
        if (!ent_live[id]) begin
          r.status = STAT_NOT_USED;
          r.mask   = ent_mask[id];
        end else begin
          ent_mask[id] = '0;
          ent_live[id] = 1'b0;
          free_ids.push_back(id);
          hits = live_ids.find_first_index(x) with (x == id);
          if (hits.size() != 0) live_ids.delete(hits[0]);
        end
      end
      OP_ADD: begin
        r.rid = id;
        ent_mask[id] = ent_mask[id] | add;
        r.mask = ent_mask[id];
        if (n == 0) begin
          r.status = STAT_NO_SYS;
        end else begin
          for (int k = 0; k < n; k++)
            if ((r.mask & sys_mask[k]) == sys_mask[k]) r.member[k] = 1'b1;
        end
      end
      default: r.rid = id;
    endcase
    result_q.push_back(r);
  endfunction

  function automatic void check_result(logic [OUT_TDATA_W-1:0] d);
    alloc_result_t got;
    alloc_result_t want;
    got.status = status_e'(d[STATUS_W-1:0]);
    got.rid    = d[STATUS_W +: ID_W];
    got.member = d[STATUS_W + ID_W +: MEMBER_W];
    got.mask   = d[STATUS_W + ID_W + MEMBER_W +: MASK_W];
    if (result_q.size() == 0) begin
      $error("result with nothing expected: status %0d id %0d", got.status, got.rid);
      err_cnt++;
      return;
    end
    want = result_q.pop_front();
    if (got.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      err_cnt++;
    end
    if (got.rid !== want.rid) begin
      $error("result_id: expected %0d, got %0d", want.rid, got.rid);
      err_cnt++;
    end
    if (got.member !== want.member) begin
      $error("member_of: expected %h, got %h", want.member, got.member);
      err_cnt++;
    end
    if (got.mask !== want.mask) begin
      $error("entity_mask: expected %h, got %h", want.mask, got.mask);
      err_cnt++;
    end
  endfunction

  // result sink with random stalls and a few long hold-offs
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      check_result(m_axis_tdata);
      results_seen++;
      if (results_seen % 400 == 30) sink_hold = 200;
    end
    if (sink_hold > 0) begin
      sink_hold--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !(snk_gaps && $urandom_range(0, 99) < 25);
    end
  end

  task automatic source_gap();
    if (src_gaps && $urandom_range(0, 99) < 25) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < 50);
    end
  endtask

  task automatic offer_req(op_e op, idx_t id, mask_t add, bit typed, alloc_result_t want);
    s_axis_tdata  <= {{(IN_TDATA_W - IN_RAW_W){1'b0}}, add, id, op};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    model_alloc_op(op, id, add);
    if (typed) result_q[result_q.size() - 1] = want;
  endtask

  // every request yields a result, so an empty queue means the block is idle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (result_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, mask_t val);
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    model_reg_write(idx, val);
  endtask

  function automatic mask_t sparse_mask();
    return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
  endfunction

  task automatic reconfig(logic [SC_W-1:0] count);
    drain();
    write_reg(CFG_SYSTEM_COUNT, mask_t'(count));
    for (int k = 0; k < MASK_REGS; k++)
      write_reg(CFG_IDX_W'(int'(CFG_SYSTEM_MASK_0) + k),
                ($urandom_range(0, 7) == 0) ? '0 : sparse_mask());
    write_reg(CFG_TOP_IDX, {$urandom, $urandom});
    cfg_valid_i <= 1'b0;
  endtask

  function automatic mask_t pick_mask();
    case ($urandom_range(0, 5))
      0: return {$urandom, $urandom};
      1: return mask_t'(1) << $urandom_range(0, MASK_W - 1);
      2: return sys_mask[$urandom_range(0, MASK_REGS - 1)];
      3: return sys_mask[$urandom_range(0, MASK_REGS - 1)] |
                sys_mask[$urandom_range(0, MASK_REGS - 1)];
      4: return '0;
      default: return ONES;
    endcase
  endfunction

  // mostly live ids for destroy and add-mask, the rest anywhere
  task automatic random_req(int create_pct, int destroy_pct);
    int    r;
    op_e   op;
    idx_t  id;
    mask_t add;
    r   = $urandom_range(0, 99);
    id  = idx_t'($urandom_range(0, MAX_ENTITIES - 1));
    add = pick_mask();
    if (r < create_pct)                    op = OP_CREATE;
    else if (r < create_pct + destroy_pct) op = OP_DESTROY;
    else if (r < 95)                       op = OP_ADD;
    else                                   op = OP_NONE;
    if ((op == OP_DESTROY || op == OP_ADD) && live_ids.size() != 0 &&
        $urandom_range(0, 9) < 8)
      id = live_ids[$urandom_range(0, live_ids.size() - 1)];
    source_gap();
    offer_req(op, id, add, 1'b0, '0);
  endtask

  task automatic run_random(int n, int create_pct, int destroy_pct);
    for (int i = 0; i < n; i++) random_req(create_pct, destroy_pct);
  endtask

  initial begin
    bit cfg_open;
    cfg_open = 1'b0;
    for (int i = 0; i < MAX_ENTITIES; i++) free_ids.push_back(idx_t'(i));
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (DIR_TAB[i]) begin
      if (DIR_TAB[i].kind == ROW_CFG) begin
        if (!cfg_open) drain();
        write_reg(DIR_TAB[i].reg_idx, DIR_TAB[i].data);
        cfg_open = 1'b1;
      end else begin
        if (cfg_open) cfg_valid_i <= 1'b0;
        cfg_open = 1'b0;
        source_gap();
        offer_req(DIR_TAB[i].op, DIR_TAB[i].id, DIR_TAB[i].data,
                  DIR_TAB[i].typed, DIR_TAB[i].want);
      end
    end

    reconfig(3'd4);
    run_random(150, 30, 25);
    reconfig(3'd3);
    run_random(80, 35, 20);

    // back to back stretch with no idling on either side
    src_gaps = 1'b0;
    snk_gaps = 1'b0;
    run_random(60, 20, 10);
    for (int i = 0; i < 4; i++) offer_req(OP_CREATE, '0, '0, 1'b0, '0);
    src_gaps = 1'b1;
    snk_gaps = 1'b1;

    reconfig(3'd7);
    run_random(100, 10, 50);
    reconfig(3'd0);
    run_random(40, 30, 30);
    reconfig(3'd2);
    run_random(60, 30, 30);
    reconfig(3'd1);
    run_random(40, 30, 30);

    s_axis_tvalid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (err_cnt == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #3_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== sim.f =====
src/eida_pkg.sv
src/eida_ram.sv
src/eida_free_list.sv
src/eida_ctrl.sv
src/entity_id_allocator_with_mask_match.sv
src/eida_checker.sv
verif/entity_id_allocator_with_mask_match_tb.sv
